@@ design/dpb_pkg.sv @@
// shared types and constants for the depth pixel back-projection block
// no dependencies; used by depth_pixel_backprojection
package dpb_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegInvDepthScale = 3'd0,
    RegCenterX       = 3'd1,
    RegCenterY       = 3'd2,
    RegInvFocalX     = 3'd3,
    RegInvFocalY     = 3'd4
  } reg_idx_e;

  // register reset values
  localparam logic [23:0] InvDepthScaleRst = 24'd16777;
  localparam logic [15:0] CenterXRst       = 16'd5120;
  localparam logic [15:0] CenterYRst       = 16'd3840;
  localparam logic [23:0] InvFocalRst      = 24'd32263;

  // pixels at or beyond this row or column lie outside the image
  localparam int unsigned CoordLimit = 2048;

  // signed 40 bit limits
  localparam logic [39:0] PosMax40 = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] NegMin40 = 40'h80_0000_0000;

  // floor of the signed quotient, saturated to 40 bits
  // q is the magnitude truncated, frac flags dropped nonzero bits
  function automatic logic [39:0] finish_axis(logic [44:0] q, logic frac, logic neg);
    logic [45:0] qn;
    logic [39:0] r;
    qn = {1'b0, q} + 46'(frac);
    if (!neg) begin
      r = (q > 45'(PosMax40)) ? PosMax40 : q[39:0];
    end else if (qn > 46'(NegMin40)) begin
      r = NegMin40;
    end else begin
      r = 40'(46'd0 - qn);
    end
    return r;
  endfunction

endpackage

@@ design/depth_pixel_backprojection.sv @@
// Pinhole back-projection of depth pixels into colored 3D points. Takes one
// pixel per clock while no point waits at a stalled output. The work is cut
// into five register stages, each holding one item: depth scaling and offset
// from the principal point, offset times depth, reciprocal focal product in
// two 24 bit halves, recombination and shift, and rounding and saturation
// into the output register. All stages advance together and hold while a
// point waits at the output, so input ready follows output ready in the same
// cycle. Pixels with zero depth or a row or column at or beyond the image
// limit produce no point.
// depends on dpb_pkg
module depth_pixel_backprojection (
  input  logic         clk_i,
  input  logic         rst_ni,
  // pixel input
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // pixel_row[10:0] pixel_col[21:11] depth_raw[37:22] blue_in[45:38]
  // green_in[53:46] red_in[61:54], zero fill above
  input  logic [63:0]  s_axis_tdata_i,
  // point output
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // point_x[39:0] point_y[79:40] point_z[111:80] blue_out[119:112]
  // green_out[127:120] red_out[135:128]
  output logic [135:0] m_axis_tdata_o,
  // configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);

  // configuration registers
  logic [23:0] inv_scale_q;
  logic [15:0] center_q [2];
  logic [23:0] inv_f_q  [2];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_scale_q <= dpb_pkg::InvDepthScaleRst;
      center_q[0] <= dpb_pkg::CenterXRst;
      center_q[1] <= dpb_pkg::CenterYRst;
      inv_f_q[0]  <= dpb_pkg::InvFocalRst;
      inv_f_q[1]  <= dpb_pkg::InvFocalRst;
    end else if (cfg_valid_i) begin
      unique case (dpb_pkg::reg_idx_e'(cfg_index_i))
        dpb_pkg::RegInvDepthScale: inv_scale_q <= cfg_data_i;
        dpb_pkg::RegCenterX:       center_q[0] <= cfg_data_i[15:0];
        dpb_pkg::RegCenterY:       center_q[1] <= cfg_data_i[15:0];
        dpb_pkg::RegInvFocalX:     inv_f_q[0]  <= cfg_data_i;
        dpb_pkg::RegInvFocalY:     inv_f_q[1]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input unpack
  logic [10:0] coord_in [2];
  logic [15:0] depth_in;
  logic [23:0] color_in;

  assign coord_in[0] = s_axis_tdata_i[21:11];
  assign coord_in[1] = s_axis_tdata_i[10:0];
  assign depth_in    = s_axis_tdata_i[37:22];
  assign color_in    = s_axis_tdata_i[61:38];

  // whole pipeline advances when the output register is free or drained
  logic ce;
  logic out_vld_q;
  logic in_acc;
  logic keep;

  assign ce              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = ce;
  assign in_acc          = s_axis_tvalid_i && ce;
  assign keep = (depth_in != 16'd0) &&
                ({2'b00, coord_in[0]} < 13'(dpb_pkg::CoordLimit)) &&
                ({2'b00, coord_in[1]} < 13'(dpb_pkg::CoordLimit));

  // valid bits
  logic vld1_q, vld2_q, vld3_q, vld4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (ce) begin
      vld1_q    <= in_acc && keep;
      vld2_q    <= vld1_q;
      vld3_q    <= vld2_q;
      vld4_q    <= vld3_q;
      out_vld_q <= vld4_q;
    end
  end

  // stage 1: depth scaling and offset from principal point
  logic [39:0] zprod;
  logic [15:0] mag_d  [2];
  logic        neg_d  [2];
  logic [15:0] scaled [2];

  always_comb begin
    zprod = 40'(depth_in) * 40'(inv_scale_q);
    for (int a = 0; a < 2; a++) begin
      scaled[a] = {1'b0, coord_in[a], 4'b0000};
      neg_d[a]  = scaled[a] < center_q[a];
      mag_d[a]  = neg_d[a] ? (center_q[a] - scaled[a]) : (scaled[a] - center_q[a]);
    end
  end

  logic [31:0] z1_q, z2_q, z3_q, z4_q;
  logic [23:0] col1_q, col2_q, col3_q, col4_q;
  logic [15:0] mag1_q [2];
  logic        neg1_q [2], neg2_q [2], neg3_q [2], neg4_q [2];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      z1_q   <= zprod[39:8];
      col1_q <= color_in;
      for (int a = 0; a < 2; a++) begin
        mag1_q[a] <= mag_d[a];
        neg1_q[a] <= neg_d[a];
      end
    end
  end

  // stage 2: offset times depth
  logic [47:0] p2_q [2];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      z2_q   <= z1_q;
      col2_q <= col1_q;
      for (int a = 0; a < 2; a++) begin
        p2_q[a]   <= 48'(mag1_q[a]) * 48'(z1_q);
        neg2_q[a] <= neg1_q[a];
      end
    end
  end

  // stage 3: reciprocal focal product in two 24 bit halves
  logic [47:0] hi3_q [2];
  logic [47:0] lo3_q [2];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      z3_q   <= z2_q;
      col3_q <= col2_q;
      for (int a = 0; a < 2; a++) begin
        hi3_q[a]  <= 48'(p2_q[a][47:24]) * 48'(inv_f_q[a]);
        lo3_q[a]  <= 48'(p2_q[a][23:0]) * 48'(inv_f_q[a]);
        neg3_q[a] <= neg2_q[a];
      end
    end
  end

  // stage 4: recombine halves, shift by 28 and note dropped bits
  logic [48:0] s_sum [2];
  logic [44:0] q4_q  [2];
  logic        fr4_q [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      s_sum[a] = 49'(hi3_q[a]) + 49'(lo3_q[a][47:24]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      z4_q   <= z3_q;
      col4_q <= col3_q;
      for (int a = 0; a < 2; a++) begin
        q4_q[a]   <= s_sum[a][48:4];
        fr4_q[a]  <= (s_sum[a][3:0] != 4'd0) || (lo3_q[a][23:0] != 24'd0);
        neg4_q[a] <= neg3_q[a];
      end
    end
  end

  // stage 5: sign, floor rounding and saturation into the output register
  logic [39:0] x_q, y_q;
  logic [31:0] z_out_q;
  logic [23:0] col_out_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      x_q       <= dpb_pkg::finish_axis(q4_q[0], fr4_q[0], neg4_q[0]);
      y_q       <= dpb_pkg::finish_axis(q4_q[1], fr4_q[1], neg4_q[1]);
      z_out_q   <= z4_q;
      col_out_q <= col4_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {col_out_q, z_out_q, y_q, x_q};

  // a pixel without depth never enters the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (depth_in == 16'd0)) |=> !vld1_q)
    else $error("zero depth pixel entered pipeline");

  // a stalled pipeline keeps its first and fourth stage valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ce |=> $stable(vld1_q) && $stable(vld4_q))
    else $error("stage valid changed during stall");

  // non-negative offsets give non-negative coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ce && vld4_q && !neg4_q[0]) |=> !m_axis_tdata_o[39])
    else $error("x sign wrong for positive offset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ce && vld4_q && !neg4_q[1]) |=> !m_axis_tdata_o[79])
    else $error("y sign wrong for positive offset");

endmodule

@@ tb/depth_pixel_backprojection_tb.sv @@
// self-checking testbench for depth_pixel_backprojection: predicts each 3D point
// from the pixel stream and register writes, then compares every point field by field
// depends on dpb_pkg and depth_pixel_backprojection
module depth_pixel_backprojection_tb;

  localparam int ResetCycles = 12;
  localparam int DrainCycles = 12;
  localparam int StallLimit  = 4000;
  localparam int PhaseItems  = 247;
  localparam int LongHold    = 400;

  // register indexes that map to no register
  localparam logic [2:0] RegIdxSpareLo = 3'd5;
  localparam logic [2:0] RegIdxSpareHi = 3'd7;

  // saturation bounds of the lateral coordinates, widened for the product
  localparam logic signed [79:0] CoordMax = 80'(dpb_pkg::PosMax40);
  localparam logic signed [79:0] CoordMin = -80'(dpb_pkg::NegMin40);

  // input item, row in the lowest bits
  typedef struct packed {
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [15:0] depth_raw;
    logic [10:0] pixel_col;
    logic [10:0] pixel_row;
  } pixel_t;

  // result item, point_x in the lowest bits
  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [31:0] point_z;
    logic [39:0] point_y;
    logic [39:0] point_x;
  } point_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_axis_tready_o;
  pixel_t       cur_pix = '0;
  logic [63:0]  s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_ready = 1'b0;
  logic [135:0] m_axis_tdata_o;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index = '0;
  logic [23:0]  cfg_data = '0;

  // copy of the camera registers as the block should hold them
  logic [23:0]  cam_inv_scale = dpb_pkg::InvDepthScaleRst;
  logic [15:0]  cam_cx = dpb_pkg::CenterXRst;
  logic [15:0]  cam_cy = dpb_pkg::CenterYRst;
  logic [23:0]  cam_inv_fx = dpb_pkg::InvFocalRst;
  logic [23:0]  cam_inv_fy = dpb_pkg::InvFocalRst;

  pixel_t pixels_pending[$];
  point_t points_due[$];

  logic pix_fire = 1'b0;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   rx_hold_left = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;

  assign s_axis_tdata_i = {2'b00, cur_pix};

  depth_pixel_backprojection u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one lateral axis: floor((pos*16 - center) * z * inv_f / 2^28), saturated
  function automatic logic [39:0] axis_coord(logic [10:0] pos, logic [15:0] center,
                                             logic [31:0] z, logic [23:0] inv_f);
    logic signed [79:0] offs;
    logic signed [79:0] prod;
    logic signed [79:0] q;
    offs = $signed(80'(pos)) * 80'sd16 - $signed(80'(center));
    prod = offs * $signed(80'(z)) * $signed(80'(inv_f));
    q = prod >>> 28;
    if (q > CoordMax) begin
      q = CoordMax;
    end else if (q < CoordMin) begin
      q = CoordMin;
    end
    return q[39:0];
  endfunction

  task automatic check_field(string name, logic [39:0] want, logic [39:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // input acceptance and point prediction
  always @(posedge clk_i) begin : pixel_accept
    pixel_t      p;
    point_t      pt;
    logic [31:0] z;
    pix_fire = rst_ni && s_valid && s_axis_tready_o;
    if (pix_fire) begin
      p = cur_pix;
      if (p.depth_raw != 0 && p.pixel_row < dpb_pkg::CoordLimit &&
          p.pixel_col < dpb_pkg::CoordLimit) begin
        z = 32'((40'(p.depth_raw) * 40'(cam_inv_scale)) >> 8);
        pt.point_x   = axis_coord(p.pixel_col, cam_cx, z, cam_inv_fx);
        pt.point_y   = axis_coord(p.pixel_row, cam_cy, z, cam_inv_fy);
        pt.point_z   = z;
        pt.blue_out  = p.blue_in;
        pt.green_out = p.green_in;
        pt.red_out   = p.red_in;
        points_due.insert(points_due.size(), pt);
      end
    end
  end

  // pixel driver, fed from the pending queue
  always @(negedge clk_i) begin : pixel_source
    if (!s_valid || pix_fire) begin
      if (pixels_pending.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
        s_valid <= 1'b1;
        cur_pix <= pixels_pending.pop_front();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // point sink with random stalls and an occasional long hold-off
  always @(negedge clk_i) begin : point_sink
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // point monitor
  always @(posedge clk_i) begin : point_check
    point_t got;
    point_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got = m_axis_tdata_o;
      if (points_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected point, expected none, got %h", $time, got);
      end else begin
        want = points_due.pop_front();
        check_field("point_x", want.point_x, got.point_x);
        check_field("point_y", want.point_y, got.point_y);
        check_field("point_z", 40'(want.point_z), 40'(got.point_z));
        check_field("blue_out", 40'(want.blue_out), 40'(got.blue_out));
        check_field("green_out", 40'(want.green_out), 40'(got.green_out));
        check_field("red_out", 40'(want.red_out), 40'(got.red_out));
      end
    end
  end

  // watchdog on cycles with no accepted item of any kind
  always @(posedge clk_i) begin : watchdog
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("depth_pixel_backprojection_tb failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      dpb_pkg::RegInvDepthScale: cam_inv_scale = val;
      dpb_pkg::RegCenterX:       cam_cx = val[15:0];
      dpb_pkg::RegCenterY:       cam_cy = val[15:0];
      dpb_pkg::RegInvFocalX:     cam_inv_fx = val;
      dpb_pkg::RegInvFocalY:     cam_inv_fy = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_pixel(logic [10:0] row, logic [10:0] col, logic [15:0] depth,
                           logic [7:0] blue, logic [7:0] green, logic [7:0] red);
    pixel_t p;
    p.pixel_row = row;
    p.pixel_col = col;
    p.depth_raw = depth;
    p.blue_in   = blue;
    p.green_in  = green;
    p.red_in    = red;
    pixels_pending.insert(pixels_pending.size(), p);
  endtask

  // wait until every item is sent and every point is back, then let the pipe empty
  task automatic drain();
    while (pixels_pending.size() != 0 || s_valid) @(posedge clk_i);
    while (points_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // random camera settings, then random pixels with a full pause halfway
  task automatic run_phase(int tx_idle, int rx_stall, int rx_hold, int count);
    logic [23:0] val;
    logic [10:0] row;
    logic [10:0] col;
    logic [15:0] depth;
    int          sel;
    for (int r = dpb_pkg::RegInvDepthScale; r <= dpb_pkg::RegInvFocalY; r++) begin
      sel = $urandom_range(9, 0);
      if (sel == 0) begin
        val = '0;
      end else if (sel == 1) begin
        val = '1;
      end else if (sel < 4) begin
        val = 24'($urandom());
      end else begin
        case (r) inside
          dpb_pkg::RegInvDepthScale: val = 24'($urandom_range(20000, 1000));
          dpb_pkg::RegCenterX, dpb_pkg::RegCenterY:
            val = 24'($urandom_range(32752, 0));
          default:                   val = 24'($urandom_range(56000, 14000));
        endcase
      end
      write_reg(3'(r), val);
    end
    if ($urandom_range(1, 0) == 1) begin
      write_reg(3'($urandom_range(RegIdxSpareHi, RegIdxSpareLo)), 24'($urandom()));
    end
    @(posedge clk_i);
    tx_idle_pct  = tx_idle;
    rx_stall_pct = rx_stall;
    rx_hold_left = rx_hold;
    for (int i = 0; i < count; i++) begin
      // sender pause until everything is back
      if (i == count / 2) drain();
      sel = $urandom_range(19, 0);
      if (sel < 2) begin
        depth = '0;
      end else if (sel == 2) begin
        depth = '1;
      end else if (sel < 6) begin
        depth = 16'($urandom_range(255, 1));
      end else begin
        depth = 16'($urandom());
      end
      sel = $urandom_range(9, 0);
      row = (sel == 0) ? 11'd0 : (sel == 1) ? 11'd2047 : 11'($urandom());
      sel = $urandom_range(9, 0);
      col = (sel == 0) ? 11'd0 : (sel == 1) ? 11'd2047 : 11'($urandom());
      add_pixel(row, col, depth, 8'($urandom()), 8'($urandom()), 8'($urandom()));
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // reset settings: corners, image center, just left of and above center, no depth
    add_pixel(11'd0, 11'd0, 16'd1, 8'h00, 8'h00, 8'h00);
    add_pixel(11'd2047, 11'd2047, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    add_pixel(11'd100, 11'd200, 16'd0, 8'h12, 8'h34, 8'h56);
    add_pixel(11'd240, 11'd320, 16'd1000, 8'h01, 8'h02, 8'h03);
    add_pixel(11'd239, 11'd319, 16'd1000, 8'h80, 8'h40, 8'h20);
    add_pixel(11'd0, 11'd2047, 16'hFFFF, 8'hAA, 8'h55, 8'h0F);
    add_pixel(11'd2047, 11'd0, 16'h8000, 8'h55, 8'hAA, 8'hF0);
    drain();

    // largest scales: x saturates high, y saturates low
    write_reg(dpb_pkg::RegInvDepthScale, 24'hFF_FFFF);
    write_reg(dpb_pkg::RegCenterX, 24'h00_0000);
    write_reg(dpb_pkg::RegCenterY, 24'h00_FFFF);
    write_reg(dpb_pkg::RegInvFocalX, 24'hFF_FFFF);
    write_reg(dpb_pkg::RegInvFocalY, 24'hFF_FFFF);
    add_pixel(11'd0, 11'd2047, 16'hFFFF, 8'hFF, 8'h00, 8'hFF);
    add_pixel(11'd2047, 11'd0, 16'hFFFF, 8'h00, 8'hFF, 8'h00);
    add_pixel(11'd5, 11'd1, 16'd1, 8'h11, 8'h22, 8'h33);
    add_pixel(11'd7, 11'd9, 16'd0, 8'h44, 8'h55, 8'h66);
    drain();

    // zero reciprocals, and writes to indexes with no register
    write_reg(dpb_pkg::RegInvDepthScale, 24'h00_0000);
    write_reg(dpb_pkg::RegCenterX, 24'hFF_FFFF);
    write_reg(dpb_pkg::RegCenterY, 24'h00_0000);
    write_reg(dpb_pkg::RegInvFocalX, 24'h00_0000);
    write_reg(dpb_pkg::RegInvFocalY, 24'h00_0000);
    write_reg(RegIdxSpareLo, 24'hFF_FFFF);
    write_reg(RegIdxSpareHi, 24'h12_3456);
    add_pixel(11'd1, 11'd2047, 16'hFFFF, 8'h77, 8'h88, 8'h99);
    add_pixel(11'd2047, 11'd0, 16'd1, 8'hFE, 8'hDC, 8'hBA);
    drain();

    // zero scale leaves zero depth, so a nonzero x focal term is still checked here
    write_reg(dpb_pkg::RegInvDepthScale, 24'd16777);
    write_reg(dpb_pkg::RegInvFocalX, 24'd33554);
    add_pixel(11'd12, 11'd13, 16'd3000, 8'h01, 8'h10, 8'h11);
    add_pixel(11'd1500, 11'd1900, 16'd65000, 8'h99, 8'h88, 8'h77);
    drain();

    // random traffic under each idling pattern, one with a long sink hold-off
    run_phase(0, 0, 0, PhaseItems);
    run_phase(54, 0, 0, PhaseItems);
    run_phase(0, 54, 0, PhaseItems);
    run_phase(34, 34, 0, PhaseItems);
    run_phase(0, 0, LongHold, PhaseItems);

    if (mismatches == 0 && points_due.size() == 0) begin
      $display("depth_pixel_backprojection_tb passed");
    end else begin
      $display("depth_pixel_backprojection_tb failed");
    end
    $finish;
  end

endmodule
